>>> rtl/a1te_pkg.sv
// Shared types, constants and the month table for the ASN.1 time converter.
`timescale 1ns / 1ps

package a1te_pkg;

  typedef enum logic [3:0] {
    PH_YEAR,
    PH_MONTH,
    PH_DAY,
    PH_HOUR,
    PH_MINUTE,
    PH_SECOPT,
    PH_SEC,
    PH_FRAC,
    PH_ZONE,
    PH_OFFH,
    PH_OFFM,
    PH_TAIL,
    PH_ERROR,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FORMAT = 2'd1,
    ST_RANGE  = 2'd2,
    ST_LOCAL  = 2'd3
  } status_e;

  localparam logic [1:0] KIND_GEN = 2'd1;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_Z     = 8'h5a;

  localparam int EPOCH_YEAR    = 1970;
  localparam int UTC_PIVOT     = 50;
  localparam int CENTURY_19    = 1900;
  localparam int CENTURY_20    = 2000;
  localparam int DAYS_PER_YEAR = 365;
  localparam int SECS_PER_DAY  = 86400;
  // floor(n/100) == (n * RECIP_100) >> RECIP_SHIFT for n below 16384
  localparam int RECIP_100     = 5243;
  localparam int RECIP_SHIFT   = 19;
  // year + 399 keeps the leap count argument non-negative; the bias removes
  // the extra 400-year block (97) and the leap days before 1970 (477)
  localparam int YEAR_SHIFT    = 399;
  localparam int LEAP_BIAS     = 574;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_t;

  // days before the first of a month in a common year
  function automatic logic [8:0] cum_days(input logic [3:0] month);
    logic [8:0] d;
    unique case (month)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

>>> rtl/a1te_days.sv
// Calendar pipeline: held date fields to seconds of midnight since the epoch.
`timescale 1ns / 1ps

module a1te_days (
  input  logic                 clk_i,
  input  a1te_pkg::date_t      date_i,
  output logic signed [39:0]   day_sec_o
);

  logic [13:0]        year1_q;
  logic [7:0]         qa_q, qa_d, qb_q, qb_d;
  logic signed [23:0] yday_q, yday_d;
  logic               leap_q, leap_d;
  logic signed [23:0] daytot_q, daytot_d;
  logic signed [39:0] day_sec_q, day_sec_d;

  logic [14:0] n0, n1;
  logic [27:0] prod_a, prod_b;
  logic [12:0] leaps;
  logic signed [23:0] ydiff;
  logic [13:0] r100;
  logic        late_month;

  // stage 1: divide by 100 through reciprocal multiplies
  always_comb begin
    n0     = 15'(date_i.year) + 15'(a1te_pkg::YEAR_SHIFT);
    prod_a = 28'(n0) * 28'(a1te_pkg::RECIP_100);
    prod_b = 28'(date_i.year) * 28'(a1te_pkg::RECIP_100);
    qa_d   = prod_a[a1te_pkg::RECIP_SHIFT +: 8];
    qb_d   = prod_b[a1te_pkg::RECIP_SHIFT +: 8];
  end

  // stage 2: days from the epoch to Jan 1, and the leap flag
  always_comb begin
    n1     = 15'(year1_q) + 15'(a1te_pkg::YEAR_SHIFT);
    leaps  = 13'(n1[14:2]) - 13'(qa_q) + 13'(qa_q[7:2]);
    ydiff  = $signed(24'(year1_q)) - 24'(a1te_pkg::EPOCH_YEAR);
    yday_d = ydiff * 24'(a1te_pkg::DAYS_PER_YEAR) + $signed(24'(leaps))
             - 24'(a1te_pkg::LEAP_BIAS);
    r100   = year1_q - 14'(qb_q) * 14'd100;
    leap_d = (year1_q[1:0] == 2'b00) && ((r100 != 14'd0) || (qb_q[1:0] == 2'b00));
  end

  // stage 3: day number; stage 4: scale to seconds
  always_comb begin
    late_month = leap_q && (date_i.month > 4'd2);
    daytot_d   = yday_q + $signed(24'(a1te_pkg::cum_days(date_i.month)))
                 + $signed(24'(late_month)) + $signed(24'(date_i.day)) - 24'sd1;
    day_sec_d  = 40'(daytot_q) * 40'(a1te_pkg::SECS_PER_DAY);
  end

  always_ff @(posedge clk_i) begin
    year1_q   <= date_i.year;
    qa_q      <= qa_d;
    qb_q      <= qb_d;
    yday_q    <= yday_d;
    leap_q    <= leap_d;
    daytot_q  <= daytot_d;
    day_sec_q <= day_sec_d;
  end

  assign day_sec_o = day_sec_q;

endmodule

>>> rtl/asn1_time_to_epoch_unit.sv
// Top level: ASN.1 UTCTime / GeneralizedTime character stream to Unix seconds.
//
// Usage: feed one string character per beat on the input channel (ch_i, with
// time_kind_i sampled on the first character and last_i on the final one).
// Each string yields exactly one beat on the output channel: epoch_seconds_o
// and status_o (ok, format error, out of range, local time unsupported).
// Throughput is one character per cycle while in_ready_o is high; strings may
// follow back to back. After the final character is accepted, the result is
// loaded into the finish register and then into the output register, which
// holds the result of the final wide add and range check.
// The date fields feed a four-register calendar pipeline that runs every
// cycle; a well formed string always carries at least five characters after
// the day field, which covers that pipeline depth.
// Reset returns the parser to the start of a string with no result pending.
// When the receiver stalls, the output register holds its beat, the finish
// register can hold one more result, and input is refused only while both
// are full.
`timescale 1ns / 1ps

module asn1_time_to_epoch_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         ch_i,
  input  logic [1:0]         time_kind_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [38:0] epoch_seconds_o,
  output logic [1:0]         status_o
);

  a1te_pkg::phase_e  phase_q, phase_d;
  a1te_pkg::status_e err_q, err_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [13:0] accum_q, accum_d;
  logic [13:0] year_q, year_d;
  logic [3:0]  month_q, month_d;
  logic [4:0]  day_q, day_d;
  logic [4:0]  hour_q, hour_d;
  logic [5:0]  minute_q, minute_d;
  logic [5:0]  second_q, second_d;
  logic [10:0] zone_q, zone_d;
  logic        zneg_q, zneg_d;
  logic [1:0]  kind_q, kind_d;

  logic              in_acc;
  logic              res_done;
  a1te_pkg::status_e res_err;
  logic [10:0]       res_zone;
  logic              res_zneg;

  a1te_pkg::date_t    date;
  logic signed [39:0] day_sec;
  logic [16:0]        tod;

  // finish register
  logic               f_valid_q, f_valid_d;
  logic               f_done_q;
  a1te_pkg::status_e  f_err_q;
  logic [10:0]        f_zone_q;
  logic               f_zneg_q;
  logic               f_pre_q;
  logic [16:0]        f_tod_q;
  logic signed [39:0] f_day_sec_q;

  // output register
  logic               out_valid_q, out_valid_d;
  logic signed [38:0] epoch_q, epoch_d;
  a1te_pkg::status_e  status_q, status_d;

  logic o_free, f_adv;

  assign o_free     = !out_valid_q || out_ready_i;
  assign f_adv      = f_valid_q && o_free;
  assign in_ready_o = !f_valid_q || o_free;
  assign in_acc     = in_valid_i && in_ready_o;

  // ---------------- character parser ----------------
  always_comb begin : parse
    logic              is_digit;
    logic [17:0]       acc_wide;
    logic [13:0]       v;
    logic [2:0]        cnt_inc;
    logic [2:0]        len;
    logic              gen;
    logic              in_range;
    logic              bad;
    logic              zc;
    a1te_pkg::phase_e  ph;

    phase_d  = phase_q;
    err_d    = err_q;
    cnt_d    = cnt_q;
    accum_d  = accum_q;
    year_d   = year_q;
    month_d  = month_q;
    day_d    = day_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    second_d = second_q;
    zone_d   = zone_q;
    zneg_d   = zneg_q;
    kind_d   = kind_q;
    res_done = 1'b0;
    res_err  = a1te_pkg::ST_OK;
    res_zone = zone_q;
    res_zneg = zneg_q;

    is_digit = (ch_i >= a1te_pkg::CH_0) && (ch_i <= a1te_pkg::CH_9);
    acc_wide = 18'(accum_q) * 18'd10 + 18'(ch_i[3:0]);
    v        = acc_wide[13:0];
    cnt_inc  = cnt_q + 3'd1;
    len      = 3'd2;
    gen      = 1'b0;
    in_range = 1'b1;
    bad      = 1'b0;
    zc       = 1'b0;
    ph       = phase_q;

    if (in_acc) begin
      if (phase_q == a1te_pkg::PH_YEAR && cnt_q == 3'd0) begin
        kind_d = time_kind_i;
        if (time_kind_i > a1te_pkg::KIND_GEN) begin
          phase_d = a1te_pkg::PH_ERROR;
          err_d   = a1te_pkg::ST_FORMAT;
        end
      end
      gen = (kind_d == a1te_pkg::KIND_GEN);
      ph  = phase_d;
      len = (ph == a1te_pkg::PH_YEAR && gen) ? 3'd4 : 3'd2;

      if (ph != a1te_pkg::PH_ERROR && ph != a1te_pkg::PH_DONE && ch_i != a1te_pkg::CH_NUL) begin
        unique case (ph)
          a1te_pkg::PH_YEAR, a1te_pkg::PH_MONTH, a1te_pkg::PH_DAY, a1te_pkg::PH_HOUR,
          a1te_pkg::PH_MINUTE, a1te_pkg::PH_SEC, a1te_pkg::PH_OFFH,
          a1te_pkg::PH_OFFM: begin
            if (!is_digit) begin
              bad = 1'b1;
            end else if (cnt_inc < len) begin
              accum_d = v;
              cnt_d   = cnt_inc;
            end else begin
              accum_d = '0;
              cnt_d   = '0;
              unique case (ph)
                a1te_pkg::PH_MONTH: in_range = (v >= 14'd1) && (v <= 14'd12);
                a1te_pkg::PH_DAY:   in_range = (v >= 14'd1) && (v <= 14'd31);
                a1te_pkg::PH_HOUR:  in_range = (v <= 14'd23);
                a1te_pkg::PH_OFFH:  in_range = (v <= 14'd12);
                a1te_pkg::PH_MINUTE, a1te_pkg::PH_SEC,
                a1te_pkg::PH_OFFM:  in_range = (v <= 14'd59);
                default:            in_range = 1'b1;
              endcase
              if (!in_range) begin
                bad = 1'b1;
              end else begin
                unique case (ph)
                  a1te_pkg::PH_MONTH: begin
                    month_d = v[3:0];
                    phase_d = a1te_pkg::PH_DAY;
                  end
                  a1te_pkg::PH_DAY: begin
                    day_d   = v[4:0];
                    phase_d = a1te_pkg::PH_HOUR;
                  end
                  a1te_pkg::PH_HOUR: begin
                    hour_d  = v[4:0];
                    phase_d = a1te_pkg::PH_MINUTE;
                  end
                  a1te_pkg::PH_MINUTE: begin
                    minute_d = v[5:0];
                    phase_d  = a1te_pkg::PH_SECOPT;
                  end
                  a1te_pkg::PH_SEC: begin
                    second_d = v[5:0];
                    phase_d  = gen ? a1te_pkg::PH_FRAC : a1te_pkg::PH_ZONE;
                  end
                  a1te_pkg::PH_OFFH: begin
                    zone_d  = 11'(v[3:0]) * 11'd60;
                    phase_d = a1te_pkg::PH_OFFM;
                  end
                  a1te_pkg::PH_OFFM: begin
                    zone_d  = zone_q + 11'(v[5:0]);
                    phase_d = a1te_pkg::PH_TAIL;
                  end
                  default: begin
                    // two-digit years pivot at 50 into 19xx / 20xx
                    if (gen) begin
                      year_d = v;
                    end else if (v < 14'(a1te_pkg::UTC_PIVOT)) begin
                      year_d = v + 14'(a1te_pkg::CENTURY_20);
                    end else begin
                      year_d = v + 14'(a1te_pkg::CENTURY_19);
                    end
                    phase_d = a1te_pkg::PH_MONTH;
                  end
                endcase
              end
            end
          end
          a1te_pkg::PH_SECOPT: begin
            if (is_digit) begin
              accum_d = 14'(ch_i[3:0]);
              cnt_d   = 3'd1;
              phase_d = a1te_pkg::PH_SEC;
            end else if (gen && (ch_i == a1te_pkg::CH_DOT || ch_i == a1te_pkg::CH_COMMA)) begin
              phase_d = a1te_pkg::PH_FRAC;
            end else begin
              zc = 1'b1;
            end
          end
          a1te_pkg::PH_FRAC: begin
            if (!(is_digit || ch_i == a1te_pkg::CH_DOT || ch_i == a1te_pkg::CH_COMMA)) begin
              zc = 1'b1;
            end
          end
          a1te_pkg::PH_ZONE: zc = 1'b1;
          default:           bad = 1'b1;
        endcase

        if (zc) begin
          if (ch_i == a1te_pkg::CH_Z) begin
            phase_d = a1te_pkg::PH_TAIL;
          end else if (ch_i == a1te_pkg::CH_PLUS || ch_i == a1te_pkg::CH_MINUS) begin
            zneg_d  = (ch_i == a1te_pkg::CH_MINUS);
            phase_d = a1te_pkg::PH_OFFH;
          end else begin
            bad = 1'b1;
          end
        end
        if (bad) begin
          phase_d = a1te_pkg::PH_ERROR;
          err_d   = a1te_pkg::ST_FORMAT;
        end
      end

      // end of string: a NUL character or the final beat
      if (phase_d != a1te_pkg::PH_ERROR && phase_d != a1te_pkg::PH_DONE &&
          (ch_i == a1te_pkg::CH_NUL || last_i)) begin
        if (phase_d == a1te_pkg::PH_TAIL) begin
          phase_d = a1te_pkg::PH_DONE;
        end else if (phase_d == a1te_pkg::PH_FRAC || (phase_d == a1te_pkg::PH_SECOPT && gen)) begin
          phase_d = a1te_pkg::PH_ERROR;
          err_d   = a1te_pkg::ST_LOCAL;
        end else begin
          phase_d = a1te_pkg::PH_ERROR;
          err_d   = a1te_pkg::ST_FORMAT;
        end
      end

      if (last_i) begin
        res_done = (phase_d == a1te_pkg::PH_DONE);
        res_err  = err_d;
        res_zone = zone_d;
        res_zneg = zneg_d;
        phase_d  = a1te_pkg::PH_YEAR;
        err_d    = a1te_pkg::ST_OK;
        cnt_d    = '0;
        accum_d  = '0;
        year_d   = '0;
        month_d  = '0;
        day_d    = '0;
        hour_d   = '0;
        minute_d = '0;
        second_d = '0;
        zone_d   = '0;
        zneg_d   = 1'b0;
        kind_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= a1te_pkg::PH_YEAR;
      err_q    <= a1te_pkg::ST_OK;
      cnt_q    <= '0;
      accum_q  <= '0;
      year_q   <= '0;
      month_q  <= '0;
      day_q    <= '0;
      hour_q   <= '0;
      minute_q <= '0;
      second_q <= '0;
      zone_q   <= '0;
      zneg_q   <= 1'b0;
      kind_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      err_q    <= err_d;
      cnt_q    <= cnt_d;
      accum_q  <= accum_d;
      year_q   <= year_d;
      month_q  <= month_d;
      day_q    <= day_d;
      hour_q   <= hour_d;
      minute_q <= minute_d;
      second_q <= second_d;
      zone_q   <= zone_d;
      zneg_q   <= zneg_d;
      kind_q   <= kind_d;
    end
  end

  // ---------------- calendar pipeline ----------------
  assign date.year  = year_q;
  assign date.month = month_q;
  assign date.day   = day_q;

  a1te_days u_days (
    .clk_i     (clk_i),
    .date_i    (date),
    .day_sec_o (day_sec)
  );

  assign tod = 17'(hour_q) * 17'd3600 + 17'(minute_q) * 17'd60 + 17'(second_q);

  // ---------------- finish register ----------------
  always_comb begin
    f_valid_d = f_valid_q;
    if (in_acc && last_i) begin
      f_valid_d = 1'b1;
    end else if (f_adv) begin
      f_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else begin
      f_valid_q <= f_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && last_i) begin
      f_done_q    <= res_done;
      f_err_q     <= res_err;
      f_zone_q    <= res_zone;
      f_zneg_q    <= res_zneg;
      f_pre_q     <= (year_q < 14'(a1te_pkg::EPOCH_YEAR));
      f_tod_q     <= tod;
      f_day_sec_q <= day_sec;
    end
  end

  // ---------------- output register ----------------
  always_comb begin : finish
    logic [15:0]        zsec;
    logic signed [39:0] r;
    logic               range_bad;

    zsec = 16'(f_zone_q) * 16'd60;
    // subtracting a negative offset adds it back
    r = f_day_sec_q + $signed(40'(f_tod_q))
        + (f_zneg_q ? $signed(40'(zsec)) : -$signed(40'(zsec)));
    range_bad = f_pre_q ? !r[39] : r[39];

    if (!f_done_q) begin
      epoch_d  = '0;
      status_d = f_err_q;
    end else if (range_bad) begin
      epoch_d  = '0;
      status_d = a1te_pkg::ST_RANGE;
    end else begin
      epoch_d  = r[38:0];
      status_d = a1te_pkg::ST_OK;
    end

    out_valid_d = out_valid_q;
    if (f_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (f_adv) begin
      epoch_q  <= epoch_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign epoch_seconds_o = epoch_q;
  assign status_o        = status_q;

  // ---------------- assertions ----------------
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != a1te_pkg::ST_OK) |-> (epoch_seconds_o == '0))
    else $error("nonzero seconds on an error beat");

  a_done_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == a1te_pkg::PH_DONE) |-> (err_q == a1te_pkg::ST_OK))
    else $error("finished string carries an error code");

  a_error_coded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == a1te_pkg::PH_ERROR) |-> (err_q != a1te_pkg::ST_OK))
    else $error("error phase without an error code");

  a_finish_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(f_valid_q) |-> $past(in_valid_i && in_ready_o && last_i))
    else $error("result raised without a final character");

  a_digit_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q < 3'd4) && ((cnt_q == 3'd0) || (phase_q != a1te_pkg::PH_DONE)))
    else $error("digit count out of step");

endmodule

>>> tb/tb_asn1_time_to_epoch_unit.sv
// Testbench for the ASN.1 time string to Unix seconds converter.
`timescale 1ns / 1ps

module tb_asn1_time_to_epoch_unit;

  localparam logic [1:0] KIND_UTC      = 2'd0;
  localparam logic [1:0] KIND_OTHER    = 2'd2;
  localparam logic [1:0] KIND_RESERVED = 2'd3;
  localparam int MONTH_DAYS[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int ODD_YEARS[7]   = '{0, 9999, 1969, 1970, 1900, 2000, 2100};
  localparam int RANDOM_CHARS   = 250;
  localparam int MIN_STRINGS    = 40;

  typedef struct {
    logic signed [38:0] seconds;
    a1te_pkg::status_e  status;
  } epoch_result_t;

  // Parses the character stream alongside the block and queues the expected
  // result of every string.
  class asn1_epoch_tracker;
    a1te_pkg::phase_e  phase;
    int                digits, accum, year, month, day, hour, minute, second, zone_min;
    bit                zone_neg;
    a1te_pkg::status_e err;
    logic [1:0]        string_kind;
    epoch_result_t     pending_epochs[$];
    int                errors;

    function new();
      clear();
      errors = 0;
    endfunction

    function void clear();
      phase = a1te_pkg::PH_YEAR;
      digits = 0; accum = 0; year = 0; month = 0; day = 0; hour = 0;
      minute = 0; second = 0; zone_min = 0; zone_neg = 0;
      err = a1te_pkg::ST_OK; string_kind = KIND_UTC;
    endfunction

    function void fail(a1te_pkg::status_e code);
      err = code;
      phase = a1te_pkg::PH_ERROR;
    endfunction

    function bit is_digit(logic [7:0] ch);
      return ch >= a1te_pkg::CH_0 && ch <= a1te_pkg::CH_9;
    endfunction

    // -1 bad digit or value, 0 field still open, 1 field complete
    function int take_digit(logic [7:0] ch, int len, int lo, int hi, output int v);
      v = 0;
      if (!is_digit(ch)) return -1;
      accum = (accum * 10 + (int'(ch) - int'(a1te_pkg::CH_0))) & 'h3FFF;
      digits = (digits + 1) & 7;
      if (digits < len) return 0;
      v = accum;
      accum = 0;
      digits = 0;
      if (v < lo || v > hi) return -1;
      return 1;
    endfunction

    function void zone_char(logic [7:0] ch);
      if (ch == a1te_pkg::CH_Z) begin
        phase = a1te_pkg::PH_TAIL;
      end else if (ch == a1te_pkg::CH_PLUS || ch == a1te_pkg::CH_MINUS) begin
        zone_neg = (ch == a1te_pkg::CH_MINUS);
        phase = a1te_pkg::PH_OFFH;
      end else begin
        fail(a1te_pkg::ST_FORMAT);
      end
    endfunction

    function void parse_char(logic [7:0] ch);
      bit gen;
      int v, r, len, lo, hi;
      gen = (string_kind == a1te_pkg::KIND_GEN);
      case (phase)
        a1te_pkg::PH_YEAR, a1te_pkg::PH_MONTH, a1te_pkg::PH_DAY, a1te_pkg::PH_HOUR,
        a1te_pkg::PH_MINUTE, a1te_pkg::PH_SEC, a1te_pkg::PH_OFFH,
        a1te_pkg::PH_OFFM: begin
          len = 2;
          lo = 0;
          hi = 59;
          case (phase)
            a1te_pkg::PH_YEAR: begin
              len = gen ? 4 : 2;
              hi = gen ? 9999 : 99;
            end
            a1te_pkg::PH_MONTH: begin
              lo = 1;
              hi = 12;
            end
            a1te_pkg::PH_DAY: begin
              lo = 1;
              hi = 31;
            end
            a1te_pkg::PH_HOUR: hi = 23;
            a1te_pkg::PH_OFFH: hi = 12;
            default: ;
          endcase
          r = take_digit(ch, len, lo, hi, v);
          if (r < 0) begin
            fail(a1te_pkg::ST_FORMAT);
          end else if (r > 0) begin
            case (phase)
              a1te_pkg::PH_YEAR: begin
                year = gen ? v : v + ((v < 50) ? 2000 : 1900);
                phase = a1te_pkg::PH_MONTH;
              end
              a1te_pkg::PH_MONTH: begin
                month = v;
                phase = a1te_pkg::PH_DAY;
              end
              a1te_pkg::PH_DAY: begin
                day = v;
                phase = a1te_pkg::PH_HOUR;
              end
              a1te_pkg::PH_HOUR: begin
                hour = v;
                phase = a1te_pkg::PH_MINUTE;
              end
              a1te_pkg::PH_MINUTE: begin
                minute = v;
                phase = a1te_pkg::PH_SECOPT;
              end
              a1te_pkg::PH_SEC: begin
                second = v;
                phase = gen ? a1te_pkg::PH_FRAC : a1te_pkg::PH_ZONE;
              end
              a1te_pkg::PH_OFFH: begin
                zone_min = v * 60;
                phase = a1te_pkg::PH_OFFM;
              end
              default: begin
                zone_min = (zone_min + v) & 'h7FF;
                phase = a1te_pkg::PH_TAIL;
              end
            endcase
          end
        end
        a1te_pkg::PH_SECOPT: begin
          if (is_digit(ch)) begin
            accum = int'(ch) - int'(a1te_pkg::CH_0);
            digits = 1;
            phase = a1te_pkg::PH_SEC;
          end else if (gen && (ch == a1te_pkg::CH_DOT || ch == a1te_pkg::CH_COMMA)) begin
            phase = a1te_pkg::PH_FRAC;
          end else begin
            zone_char(ch);
          end
        end
        a1te_pkg::PH_FRAC: begin
          // fraction digits and separators are skipped
          if (!(ch == a1te_pkg::CH_DOT || ch == a1te_pkg::CH_COMMA || is_digit(ch)))
            zone_char(ch);
        end
        a1te_pkg::PH_ZONE: zone_char(ch);
        default: fail(a1te_pkg::ST_FORMAT);
      endcase
    endfunction

    function void end_string();
      if (phase == a1te_pkg::PH_TAIL) phase = a1te_pkg::PH_DONE;
      else if (phase == a1te_pkg::PH_FRAC ||
               (phase == a1te_pkg::PH_SECOPT && string_kind == a1te_pkg::KIND_GEN))
        fail(a1te_pkg::ST_LOCAL);
      else fail(a1te_pkg::ST_FORMAT);
    endfunction

    function longint seconds_since_epoch();
      longint y, off, r, c;
      bit leap;
      y = year;
      off = zone_neg ? -longint'(zone_min) : longint'(zone_min);
      r = longint'(second) + (longint'(minute) - off) * 60 + longint'(hour) * 3600
          + (longint'(day) - 1) * 86400;
      leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      for (int m = 0; m + 1 < month && m < 12; m++)
        r += longint'(MONTH_DAYS[m] + ((m == 1 && leap) ? 1 : 0)) * 86400;
      r += (y - 1970) * 31536000;
      if (y < 1970) begin
        r -= ((1972 - y) / 4) * 86400;
        for (c = 1900; c >= y; c -= 100)
          if (c % 400 != 0) r += 86400;
        if (r >= 0) err = a1te_pkg::ST_RANGE;
      end else begin
        r += ((y - 1969) / 4) * 86400;
        for (c = 2100; c < y; c += 100)
          if (c % 400 != 0) r -= 86400;
        if (r < 0) err = a1te_pkg::ST_RANGE;
      end
      return r;
    endfunction

    function void note_char(logic [7:0] ch, logic [1:0] kind, logic last);
      epoch_result_t res;
      longint r;
      if (phase == a1te_pkg::PH_YEAR && digits == 0) begin
        string_kind = kind;
        if (kind > a1te_pkg::KIND_GEN) fail(a1te_pkg::ST_FORMAT);
      end
      if (phase != a1te_pkg::PH_ERROR && phase != a1te_pkg::PH_DONE) begin
        if (ch == a1te_pkg::CH_NUL) end_string();
        else parse_char(ch);
      end
      if (!last) return;
      if (phase != a1te_pkg::PH_ERROR && phase != a1te_pkg::PH_DONE) end_string();
      res.seconds = '0;
      if (phase == a1te_pkg::PH_DONE) begin
        r = seconds_since_epoch();
        if (err == a1te_pkg::ST_OK) res.seconds = r[38:0];
      end
      res.status = (phase == a1te_pkg::PH_DONE || err != a1te_pkg::ST_OK) ?
                   err : a1te_pkg::ST_FORMAT;
      pending_epochs.push_back(res);
      clear();
    endfunction

    function void check_result(logic signed [38:0] seconds, logic [1:0] status);
      epoch_result_t want;
      if (pending_epochs.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, seconds %0d status %0d", $time, seconds, status);
        return;
      end
      want = pending_epochs.pop_front();
      if (seconds !== want.seconds) begin
        errors++;
        $display("%0t: epoch_seconds expected %0d actual %0d", $time, want.seconds, seconds);
      end
      if (status !== want.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, want.status, status);
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [7:0]         ch_i = '0;
  logic [1:0]         time_kind_i = '0;
  logic               last_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [38:0] epoch_seconds_o;
  logic [1:0]         status_o;

  asn1_epoch_tracker tracker = new();
  logic [7:0]        text_q[$];
  int                random_chars;
  int                strings_sent;
  int                out_mode;

  asn1_time_to_epoch_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .ch_i           (ch_i),
    .time_kind_i    (time_kind_i),
    .last_i         (last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .epoch_seconds_o(epoch_seconds_o),
    .status_o       (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // mode 0: no idling, 1: any wait, 2: occasional waits
  function int idle_len(int mode);
    if (mode == 0) return 0;
    if (mode == 1) return $urandom_range(0, 16);
    return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 16) : 0;
  endfunction

  function void load_text(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function void push_num(int v, int n);
    int div;
    div = 1;
    repeat (n - 1) div *= 10;
    repeat (n) begin
      text_q.push_back(a1te_pkg::CH_0 + 8'((v / div) % 10));
      div /= 10;
    end
  endfunction

  function logic [7:0] punct_char();
    case ($urandom_range(0, 4))
      0: return a1te_pkg::CH_DOT;
      1: return a1te_pkg::CH_COMMA;
      2: return a1te_pkg::CH_PLUS;
      3: return a1te_pkg::CH_MINUS;
      default: return a1te_pkg::CH_Z;
    endcase
  endfunction

  // time string with random content; well formed, except that one draw in ten has no zone
  function void make_time_text(output logic [1:0] kind);
    int year;
    text_q.delete();
    kind = $urandom_range(0, 1) ? a1te_pkg::KIND_GEN : KIND_UTC;
    if (kind == a1te_pkg::KIND_GEN) begin
      case ($urandom_range(0, 3))
        0: year = $urandom_range(0, 9999);
        1: year = $urandom_range(1890, 2110);
        2: year = ODD_YEARS[$urandom_range(0, 6)];
        default: year = $urandom_range(1960, 2040);
      endcase
      push_num(year, 4);
    end else begin
      push_num($urandom_range(0, 99), 2);
    end
    push_num($urandom_range(1, 12), 2);
    push_num($urandom_range(1, 31), 2);
    push_num($urandom_range(0, 23), 2);
    push_num($urandom_range(0, 59), 2);
    if ($urandom_range(0, 9) < 7) push_num($urandom_range(0, 59), 2);
    if (kind == a1te_pkg::KIND_GEN && $urandom_range(0, 3) == 0) begin
      text_q.push_back($urandom_range(0, 1) ? a1te_pkg::CH_DOT : a1te_pkg::CH_COMMA);
      repeat ($urandom_range(0, 4))
        text_q.push_back($urandom_range(0, 5) == 0 ? a1te_pkg::CH_COMMA :
                         a1te_pkg::CH_0 + 8'($urandom_range(0, 9)));
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3: text_q.push_back(a1te_pkg::CH_Z);
      9: ;
      default: begin
        text_q.push_back($urandom_range(0, 1) ? a1te_pkg::CH_PLUS : a1te_pkg::CH_MINUS);
        push_num($urandom_range(0, 12), 2);
        push_num($urandom_range(0, 59), 2);
      end
    endcase
  endfunction

  function void corrupt_text(inout logic [1:0] kind);
    int pos;
    pos = $urandom_range(0, text_q.size() - 1);
    case ($urandom_range(0, 5))
      0: text_q[pos] = 8'($urandom_range(0, 255));
      1: while (text_q.size() > pos + 1) void'(text_q.pop_back());
      2: repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(0, 255)));
      3: text_q.insert(pos, a1te_pkg::CH_NUL);
      4: text_q[pos] = a1te_pkg::CH_0 + 8'($urandom_range(0, 9));
      default: kind = $urandom_range(0, 1) ? KIND_OTHER : KIND_RESERVED;
    endcase
  endfunction

  function void make_noise_text(output logic [1:0] kind);
    text_q.delete();
    kind = 2'($urandom_range(0, 3));
    repeat ($urandom_range(1, 20)) begin
      case ($urandom_range(0, 3))
        0, 1: text_q.push_back(a1te_pkg::CH_0 + 8'($urandom_range(0, 9)));
        2: text_q.push_back(punct_char());
        default: text_q.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endfunction

  task automatic send_char(logic [7:0] ch, logic [1:0] kind, logic last, int mode);
    int gap;
    gap = idle_len(mode);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    ch_i <= ch;
    time_kind_i <= kind;
    last_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_char(ch, kind, last);
  endtask

  // kind only counts on the first character; later beats carry junk there
  task automatic send_text(logic [1:0] kind, int mode);
    int n;
    n = text_q.size();
    for (int i = 0; i < n; i++)
      send_char(text_q[i], (i == 0) ? kind : 2'($urandom_range(0, 3)), i == n - 1, mode);
    text_q.delete();
    strings_sent++;
  endtask

  task automatic send_literal(string s, logic [1:0] kind);
    text_q.delete();
    load_text(s);
    send_text(kind, $urandom_range(0, 2));
  endtask

  task automatic run_directed();
    send_literal("700101000000Z", KIND_UTC);
    send_literal("491231235959Z", KIND_UTC);
    send_literal("99991231235959Z", a1te_pkg::KIND_GEN);
    send_literal("00000101000000Z", a1te_pkg::KIND_GEN);
    // pre-epoch year whose offset pushes it past the epoch, and the reverse
    send_literal("19691231235959-0100", a1te_pkg::KIND_GEN);
    send_literal("19700101000000+0100", a1te_pkg::KIND_GEN);
    send_literal("20240229120000.123Z", a1te_pkg::KIND_GEN);
    send_literal("202402291200,5+1259", a1te_pkg::KIND_GEN);
    send_literal("210003010000Z", a1te_pkg::KIND_GEN);
    send_literal("190003010000Z", a1te_pkg::KIND_GEN);
    send_literal("202001011200", a1te_pkg::KIND_GEN);
    send_literal("20200101120030.5", a1te_pkg::KIND_GEN);
    send_literal("700101000000Z", KIND_OTHER);
    send_literal("Z", KIND_RESERVED);
    send_literal("7001", KIND_UTC);
    send_literal("701301000000Z", KIND_UTC);
    send_literal("700101000060Z", KIND_UTC);
    send_literal("7001010000a0Z", KIND_UTC);
    send_literal("7001010000+1300", KIND_UTC);
    send_literal("700101000000Zx", KIND_UTC);
    text_q.delete();
    load_text("700101000000Z");
    text_q.push_back(a1te_pkg::CH_NUL);
    load_text("ab");
    send_text(KIND_UTC, 2);
    load_text("7001");
    text_q.push_back(a1te_pkg::CH_NUL);
    load_text("01");
    send_text(KIND_UTC, 0);
  endtask

  // receiver: random stalls, with stall-free stretches when out_mode is 0
  initial begin
    int n;
    out_mode = 0;
    forever begin
      if ($urandom_range(0, 15) == 0) out_mode = $urandom_range(0, 2);
      n = idle_len(out_mode);
      if (n > 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && rst_ni));
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) tracker.check_result(epoch_seconds_o, status_o);
  end

  initial begin
    logic [1:0] kind;
    random_chars = 0;
    strings_sent = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    while (random_chars < RANDOM_CHARS || strings_sent < MIN_STRINGS) begin
      if ($urandom_range(0, 9) < 7) begin
        make_time_text(kind);
        if ($urandom_range(0, 3) == 0) corrupt_text(kind);
      end else begin
        make_noise_text(kind);
      end
      random_chars += text_q.size();
      send_text(kind, $urandom_range(0, 2));
    end
    in_valid_i <= 1'b0;
    while (tracker.pending_epochs.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending_epochs.size() == 0) begin
      $display("tb_asn1_time_to_epoch_unit: done, clean");
    end else begin
      $display("tb_asn1_time_to_epoch_unit: done, errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_asn1_time_to_epoch_unit: done, errors");
    $finish;
  end

endmodule

>>> files.f
rtl/a1te_pkg.sv
rtl/a1te_days.sv
rtl/asn1_time_to_epoch_unit.sv
tb/tb_asn1_time_to_epoch_unit.sv
